/* rtl/core/myci_pkg.sv */
// ----------------------------------------------------------------------------
// myci_pkg
// Widths and constants of the least y-axis intercept block.
// ----------------------------------------------------------------------------
package myci_pkg;

   // width of one coordinate field on the port
   localparam int FIELD_W    = 16;
   // coordinate width used for the arithmetic
   localparam int COORD_BITS = 16;
   // fraction bits of the Q16.16 intercept
   localparam int FRAC_BITS  = 16;
   // intercept width
   localparam int Q_W        = 32;

   // signed numerator y1*x2 - y2*x1
   localparam int PROD_W = 2 * COORD_BITS + 1;
   // magnitude of the numerator
   localparam int MAG_W  = 2 * COORD_BITS;
   // dividend (magnitude scaled by the fraction bits) and quotient width
   localparam int DIV_W  = MAG_W + FRAC_BITS;
   // step counter covers the longer of the multiply and divide sweeps
   localparam int CNT_W  = $clog2(DIV_W);

   localparam logic [Q_W-1:0] MINUS_ONE_Q = 32'hFFFF_0000;
   localparam logic [Q_W-1:0] Q_MAX       = 32'h7FFF_FFFF;
   localparam logic [Q_W-1:0] Q_MIN       = 32'h8000_0000;

   // coordinate taken from a port field: zero-extended or truncated to COORD_BITS
   function automatic logic [COORD_BITS-1:0] coord_of(input logic [FIELD_W-1:0] f);
      logic [FIELD_W+COORD_BITS-1:0] t;
      t = {{COORD_BITS{1'b0}}, f};
      return t[COORD_BITS-1:0];
   endfunction

endpackage

/* rtl/core/min_y_axis_crossing_intercept_top.sv */
// ----------------------------------------------------------------------------
// min_y_axis_crossing_intercept_top
// Least y-axis intercept over a run of line segments, bit-serial datapath.
// ----------------------------------------------------------------------------
// One segment arrives per req beat: req_tdata carries first_x, first_y,
// second_x, second_y (16 bits each, lowest first), req_tlast marks the
// final segment of a run. A segment whose x coordinates lie on opposite
// sides of the y axis gets its intercept in Q16.16, floored and saturated,
// and the least one is kept. On the last segment one rsp beat follows:
// rsp_tuser is the found flag, rsp_tdata the least intercept, or -1.0
// when nothing crossed; the running state then clears.
// A segment that does not cross needs no arithmetic. A crossing segment
// goes through a shift-add multiply of one multiplier bit per cycle,
// then a restoring divide of one quotient bit per cycle, then rounding,
// saturation and the minimum compare. A last segment adds a state that
// loads the output register. req_tready is high only between segments.
// The result sits in an output register, so the next run proceeds while
// the receiver stalls; only a second result waits for the register.
// Synchronous reset empties the output register and clears the minimum.
// ----------------------------------------------------------------------------
module min_y_axis_crossing_intercept_top
   import myci_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [4*FIELD_W-1:0] req_tdata,   // first_x, first_y, second_x, second_y
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [Q_W-1:0]       rsp_tdata,   // least_intercept
   output logic                 rsp_tuser    // found
);

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_MUL    = 8'b0000_0010,
      ST_NORM   = 8'b0000_0100,
      ST_DIV    = 8'b0000_1000,
      ST_ROUND  = 8'b0001_0000,
      ST_SAT    = 8'b0010_0000,
      ST_UPDATE = 8'b0100_0000,
      ST_EMIT   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  last_ff, last_in;
   logic                  den_neg_ff, den_neg_in;
   logic [COORD_BITS-1:0] d_ff, d_in;
   logic [COORD_BITS-1:0] mx1_ff, mx1_in;
   logic [COORD_BITS-1:0] mx2_ff, mx2_in;
   logic [PROD_W-1:0]     a_ff, a_in;
   logic [PROD_W-1:0]     b_ff, b_in;
   logic [PROD_W-1:0]     acc_ff, acc_in;
   logic                  neg_ff, neg_in;
   logic [DIV_W-1:0]      dvd_ff, dvd_in;
   logic [COORD_BITS-1:0] rem_ff, rem_in;
   logic [Q_W-1:0]        icpt_ff, icpt_in;
   logic [Q_W-1:0]        min_ff, min_in;
   logic                  any_ff, any_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [Q_W-1:0]        rsp_data_ff, rsp_data_in;
   logic                  rsp_found_ff, rsp_found_in;

   logic [COORD_BITS-1:0] x1, y1, x2, y2;
   logic [COORD_BITS:0]   den_full;
   logic [COORD_BITS:0]   den_abs;
   logic [PROD_W-1:0]     pa, pb, term;
   logic [PROD_W-1:0]     acc_abs;
   logic [COORD_BITS:0]   shifted;
   logic [COORD_BITS+1:0] diff;
   logic                  ge;
   logic                  out_free;
   logic                  req_fire;

   assign x1 = coord_of(req_tdata[FIELD_W-1:0]);
   assign y1 = coord_of(req_tdata[2*FIELD_W-1:FIELD_W]);
   assign x2 = coord_of(req_tdata[3*FIELD_W-1:2*FIELD_W]);
   assign y2 = coord_of(req_tdata[4*FIELD_W-1:3*FIELD_W]);

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign den_full = {x2[COORD_BITS-1], x2} - {x1[COORD_BITS-1], x1};
   assign den_abs  = x2[COORD_BITS-1] ? (~den_full + 1'b1) : den_full;

   // one multiplier bit of each product per cycle; the sign bit weighs negative
   assign pa   = mx2_ff[0] ? a_ff : '0;
   assign pb   = mx1_ff[0] ? b_ff : '0;
   assign term = pa - pb;

   assign acc_abs = acc_ff[PROD_W-1] ? (~acc_ff + 1'b1) : acc_ff;

   // restoring divide step
   assign shifted = {rem_ff, dvd_ff[DIV_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, d_ff};
   assign ge      = !diff[COORD_BITS+1];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      last_in      = last_ff;
      den_neg_in   = den_neg_ff;
      d_in         = d_ff;
      mx1_in       = mx1_ff;
      mx2_in       = mx2_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      dvd_in       = dvd_ff;
      rem_in       = rem_ff;
      icpt_in      = icpt_ff;
      min_in       = min_ff;
      any_in       = any_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_found_in = rsp_found_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               last_in    = req_tlast;
               den_neg_in = x2[COORD_BITS-1];
               d_in       = den_abs[COORD_BITS-1:0];
               mx1_in     = x1;
               mx2_in     = x2;
               a_in       = {{(PROD_W-COORD_BITS){y1[COORD_BITS-1]}}, y1};
               b_in       = {{(PROD_W-COORD_BITS){y2[COORD_BITS-1]}}, y2};
               acc_in     = '0;
               cnt_in     = '0;
               if (x1[COORD_BITS-1] ^ x2[COORD_BITS-1]) begin
                  state_in = ST_MUL;
               end else if (req_tlast) begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_MUL: begin
            if (cnt_ff == CNT_W'(COORD_BITS - 1)) begin
               acc_in   = acc_ff - term;
               state_in = ST_NORM;
            end else begin
               acc_in = acc_ff + term;
               cnt_in = cnt_ff + 1'b1;
            end
            a_in   = a_ff << 1;
            b_in   = b_ff << 1;
            mx1_in = mx1_ff >> 1;
            mx2_in = mx2_ff >> 1;
         end
         ST_NORM: begin
            // a negative divisor flips the sign of the quotient
            neg_in   = acc_ff[PROD_W-1] ^ den_neg_ff;
            dvd_in   = {acc_abs[MAG_W-1:0], {FRAC_BITS{1'b0}}};
            rem_in   = '0;
            cnt_in   = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in = ge ? diff[COORD_BITS-1:0] : shifted[COORD_BITS-1:0];
            dvd_in = {dvd_ff[DIV_W-2:0], ge};
            if (cnt_ff == CNT_W'(DIV_W - 1)) begin
               state_in = ST_ROUND;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ROUND: begin
            // floor of a negative quotient rounds the magnitude up
            if (neg_ff && (rem_ff != '0)) begin
               dvd_in = dvd_ff + 1'b1;
            end
            state_in = ST_SAT;
         end
         ST_SAT: begin
            if (neg_ff) begin
               if (dvd_ff > DIV_W'(Q_MIN)) begin
                  icpt_in = Q_MIN;
               end else begin
                  icpt_in = ~dvd_ff[Q_W-1:0] + 1'b1;
               end
            end else begin
               if (dvd_ff > DIV_W'(Q_MAX)) begin
                  icpt_in = Q_MAX;
               end else begin
                  icpt_in = dvd_ff[Q_W-1:0];
               end
            end
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!any_ff || ($signed(icpt_ff) < $signed(min_ff))) begin
               min_in = icpt_ff;
            end
            any_in   = 1'b1;
            state_in = last_ff ? ST_EMIT : ST_IDLE;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = any_ff;
               rsp_data_in  = any_ff ? min_ff : MINUS_ONE_Q;
               min_in       = '0;
               any_in       = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         min_ff       <= '0;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         min_ff       <= min_in;
         any_ff       <= any_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff      <= last_in;
      den_neg_ff   <= den_neg_in;
      d_ff         <= d_in;
      mx1_ff       <= mx1_in;
      mx2_ff       <= mx2_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      acc_ff       <= acc_in;
      neg_ff       <= neg_in;
      dvd_ff       <= dvd_in;
      rem_ff       <= rem_in;
      icpt_ff      <= icpt_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_found_ff <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_found_ff;

   // partial remainder stays below the divisor throughout the divide
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (rem_ff < d_ff))
      else $error("partial remainder not below divisor");

   // a crossing segment never has a zero divisor
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (d_ff != '0))
      else $error("zero divisor on a crossing segment");

   // loading a result clears the running state
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && out_free) |=> (!any_ff && min_ff == '0 && rsp_tvalid))
      else $error("running state not cleared after result");

   // no crossing reports minus one
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata == MINUS_ONE_Q))
      else $error("empty run reports wrong intercept");

endmodule
